FILE: src/rtpd_pkg.sv
// Package with shared types and constants for the RTP H.264 depacketizer.
`default_nettype none
package rtpd_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int OUT_LEN_W = 24;
    localparam int QUEUE_DEPTH = 4;

    // Packet classes.
    typedef enum logic [1:0] {
        CLS_IGNORE  = 2'd0,
        CLS_SINGLE  = 2'd1,
        CLS_FUA     = 2'd2,
        CLS_SWALLOW = 2'd3
    } pkt_class_t;

    // Register indexes.
    localparam logic REG_PT_ENABLE = 1'b0;
    localparam logic REG_PT_VALUE  = 1'b1;

    localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
    localparam logic [4:0] NAL_FUA = 5'd28;
    localparam logic [7:0] START_BYTE = 8'h01;

    // Command from front to back: up to seven results described compactly.
    // Each slot carries a verdict or a data byte.
    typedef struct packed {
        logic       pre_verdict;   // drop verdict for an abandoned frame
        logic [31:0] pre_ts;
        logic [23:0] pre_len;
        logic       start_code;    // four start code bytes
        logic       hdr_valid;     // rebuilt NAL header of a starting FU-A
        logic [7:0] hdr_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       post_verdict;
        logic       post_good;
        logic [31:0] post_ts;
        logic [23:0] post_len;
    } cmd_t;

endpackage
`default_nettype wire

FILE: src/rtpd_front.sv
// Front part: parses packets, keeps frame state and issues result commands.
`default_nettype none
module rtpd_front #(
    parameter int LENGTH_BITS = rtpd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic [7:0]    payload_byte,
    input  wire logic          first_byte,
    input  wire logic          last_byte,
    input  wire logic          marker,
    input  wire logic [6:0]    rtp_pt,
    input  wire logic [15:0]   seq_num,
    input  wire logic [31:0]   rtp_timestamp,
    input  wire logic [31:0]   ssrc,
    input  wire logic          pt_filter_enable,
    input  wire logic [6:0]    pt_value,
    output rtpd_pkg::cmd_t     cmd,
    output logic               cmd_any
);
    import rtpd_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic                   frame_active_reg, frame_active_next;
    logic [31:0]            frame_ts_reg, frame_ts_next;
    logic [31:0]            frame_ssrc_reg, frame_ssrc_next;
    logic [15:0]            expected_seq_reg, expected_seq_next;
    logic                   frame_damaged_reg, frame_damaged_next;
    logic                   fu_open_reg, fu_open_next;
    pkt_class_t             class_reg, class_next;
    logic [1:0]             pos_reg;
    logic [2:0]             nal_high_reg, nal_high_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [7:0]             fu_hdr_reg, fu_hdr_next;
    logic                   pkt_marker_reg, pkt_marker_next;

    logic [1:0]  pos;
    logic [4:0]  nal_t;
    logic        good;
    logic [2:0]  nbytes;

    // Saturating length narrowed to the output width.
    function automatic logic [23:0] sat_len(input logic [LENGTH_BITS-1:0] v);
        logic [23:0] r;
        if (LENGTH_BITS > OUT_LEN_W && (v >> OUT_LEN_W) != '0)
            r = '1;
        else
            r = 24'(v);
        return r;
    endfunction

    assign nal_t = payload_byte[4:0] & NAL_TYPE_MASK;

    // Per-item decode of one payload byte.
    always_comb
    begin
        frame_active_next  = frame_active_reg;
        frame_ts_next      = frame_ts_reg;
        frame_ssrc_next    = frame_ssrc_reg;
        expected_seq_next  = expected_seq_reg;
        frame_damaged_next = frame_damaged_reg;
        fu_open_next       = fu_open_reg;
        class_next         = class_reg;
        nal_high_next      = nal_high_reg;
        len_next           = len_reg;
        fu_hdr_next        = fu_hdr_reg;
        pkt_marker_next    = pkt_marker_reg;
        cmd                = '0;
        good               = 1'b0;
        nbytes             = 3'd0;
        pos                = pos_reg;

        if (first_byte)
        begin
            pos        = 2'd0;
            class_next = CLS_IGNORE;
            if (!(pt_filter_enable && rtp_pt != pt_value))
            begin
                pkt_marker_next = marker;
                if (!frame_active_reg || rtp_timestamp != frame_ts_reg
                    || ssrc != frame_ssrc_reg)
                begin
                    cmd.pre_verdict    = frame_active_reg;
                    cmd.pre_ts         = frame_ts_reg;
                    cmd.pre_len        = sat_len(len_reg);
                    frame_damaged_next = 1'b0;
                    fu_open_next       = 1'b0;
                    len_next           = '0;
                    frame_active_next  = 1'b1;
                    frame_ts_next      = rtp_timestamp;
                    frame_ssrc_next    = ssrc;
                end
                else if (seq_num != expected_seq_reg)
                begin
                    frame_damaged_next = 1'b1;
                    fu_open_next       = 1'b0;
                end
                expected_seq_next = seq_num + 16'd1;
                if (nal_t >= 5'd1 && nal_t <= 5'd23)
                begin
                    class_next     = CLS_SINGLE;
                    fu_open_next   = 1'b0;
                    cmd.start_code = 1'b1;
                    cmd.data_valid = 1'b1;
                    cmd.data_byte  = payload_byte;
                    nbytes         = 3'd5;
                end
                else if (nal_t == NAL_FUA)
                begin
                    class_next    = CLS_FUA;
                    nal_high_next = payload_byte[7:5];
                end
                else
                begin
                    class_next         = CLS_SWALLOW;
                    frame_damaged_next = 1'b1;
                    fu_open_next       = 1'b0;
                end
            end
        end
        else
        begin
            case (class_reg)
                CLS_SINGLE:
                begin
                    cmd.data_valid = 1'b1;
                    cmd.data_byte  = payload_byte;
                    nbytes         = 3'd1;
                end
                CLS_FUA:
                begin
                    if (pos == 2'd1)
                    begin
                        fu_hdr_next = payload_byte;
                        if (!payload_byte[7] && !fu_open_reg)
                        begin
                            frame_damaged_next = 1'b1;
                            class_next         = CLS_SWALLOW;
                        end
                    end
                    else if (pos >= 2'd2)
                    begin
                        if (pos == 2'd2 && fu_hdr_reg[7])
                        begin
                            cmd.start_code = 1'b1;
                            cmd.hdr_valid  = 1'b1;
                            cmd.hdr_byte   = {nal_high_reg, fu_hdr_reg[4:0]};
                            nbytes         = 3'd6;
                        end
                        else
                            nbytes = 3'd1;
                        cmd.data_valid = 1'b1;
                        cmd.data_byte  = payload_byte;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Length count saturates at its maximum.
        if (LEN_MAX - len_next <= LENGTH_BITS'(nbytes))
            len_next = LEN_MAX;
        else
            len_next = len_next + LENGTH_BITS'(nbytes);

        // End of packet handling.
        if (last_byte && class_next != CLS_IGNORE)
        begin
            if (class_next == CLS_FUA)
            begin
                if (pos < 2'd2)
                begin
                    frame_damaged_next = 1'b1;
                    fu_open_next       = 1'b0;
                end
                else if (fu_hdr_next[7])
                    fu_open_next = !fu_hdr_next[6];
                else if (fu_hdr_next[6])
                    fu_open_next = 1'b0;
            end
            if (pkt_marker_next)
            begin
                good = frame_active_next && len_next != '0 && !frame_damaged_next
                       && !fu_open_next;
                cmd.post_verdict   = 1'b1;
                cmd.post_good      = good;
                cmd.post_ts        = frame_ts_next;
                cmd.post_len       = sat_len(len_next);
                frame_active_next  = 1'b0;
                frame_ts_next      = '0;
                frame_ssrc_next    = '0;
                expected_seq_next  = '0;
                frame_damaged_next = 1'b0;
                fu_open_next       = 1'b0;
                len_next           = '0;
            end
        end
        if (last_byte)
            class_next = CLS_IGNORE;
    end

    assign cmd_any = cmd.pre_verdict | cmd.start_code | cmd.hdr_valid
                   | cmd.data_valid | cmd.post_verdict;

    // State registers, updated on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg  <= 1'b0;
            frame_ts_reg      <= '0;
            frame_ssrc_reg    <= '0;
            expected_seq_reg  <= '0;
            frame_damaged_reg <= 1'b0;
            fu_open_reg       <= 1'b0;
            class_reg         <= CLS_IGNORE;
            pos_reg           <= '0;
            nal_high_reg      <= '0;
            len_reg           <= '0;
            fu_hdr_reg        <= '0;
            pkt_marker_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            frame_active_reg  <= frame_active_next;
            frame_ts_reg      <= frame_ts_next;
            frame_ssrc_reg    <= frame_ssrc_next;
            expected_seq_reg  <= expected_seq_next;
            frame_damaged_reg <= frame_damaged_next;
            fu_open_reg       <= fu_open_next;
            class_reg         <= class_next;
            pos_reg           <= (pos < 2'd3) ? pos + 2'd1 : 2'd3;
            nal_high_reg      <= nal_high_next;
            len_reg           <= len_next;
            fu_hdr_reg        <= fu_hdr_next;
            pkt_marker_reg    <= pkt_marker_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/rtpd_back.sv
// Back part: command queue and result sequencer.
`default_nettype none
module rtpd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_push,
    input  wire rtpd_pkg::cmd_t cmd_in,
    output logic               cmd_room,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               is_data,
    output logic               frame_end,
    output logic               frame_good,
    output logic [23:0]        frame_length,
    output logic [31:0]        frame_timestamp,
    output logic               last_result
);
    import rtpd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg;
    logic [2:0]    step_reg, step_next;
    cmd_t          head;
    logic [3:0]    mask;
    logic [2:0]    cur;
    logic          more;
    logic          pop;
    logic          post_now, is_last;

    assign head     = mem[rd_reg];
    assign cmd_room = (cnt_reg < (PW+1)'(QUEUE_DEPTH));

    // Slots: pre verdict, four start bytes, header, data; the post verdict follows.
    assign mask = {head.data_valid, head.hdr_valid, head.start_code, head.pre_verdict};

    // Slot map: 0 pre, 1..4 start code, 5 header, 6 data; 7 post handled below.
    function automatic logic slot_on(input logic [3:0] m, input logic [2:0] s);
        logic r;
        case (s)
            3'd0: r = m[0];
            3'd1, 3'd2, 3'd3, 3'd4: r = m[1];
            3'd5: r = m[2];
            3'd6: r = m[3];
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Pick the current slot at or after step_reg, and whether more follow.
    always_comb
    begin
        cur       = 3'd7;
        more      = 1'b0;
        step_next = step_reg;
        for (int s = 0; s < 8; s++)
        begin
            if (s >= 32'(step_reg) && cur == 3'd7 && slot_on(mask, 3'(s)))
                cur = 3'(s);
        end
        for (int s = 0; s < 8; s++)
        begin
            if (cur != 3'd7 && s > 32'(cur) && slot_on(mask, 3'(s)))
                more = 1'b1;
        end
        if (cur == 3'd7)
            more = 1'b0;
        step_next = cur + 3'd1;
    end

    assign post_now  = (cur == 3'd7) && head.post_verdict;
    assign out_valid = (cnt_reg != '0) && (cur != 3'd7 || head.post_verdict);
    assign is_last   = post_now || (!more && !head.post_verdict);
    assign pop       = out_valid && out_ready && is_last;

    // Result fields of the current slot.
    always_comb
    begin
        out_byte        = 8'd0;
        is_data         = 1'b1;
        frame_end       = 1'b0;
        frame_good      = 1'b0;
        frame_length    = '0;
        frame_timestamp = '0;
        case (cur)
            3'd0:
            begin
                is_data         = 1'b0;
                frame_end       = 1'b1;
                frame_length    = head.pre_len;
                frame_timestamp = head.pre_ts;
            end
            3'd4: out_byte = START_BYTE;
            3'd5: out_byte = head.hdr_byte;
            3'd6: out_byte = head.data_byte;
            3'd7:
            begin
                is_data         = 1'b0;
                frame_end       = 1'b1;
                frame_good      = head.post_good;
                frame_length    = head.post_len;
                frame_timestamp = head.post_ts;
            end
            default: out_byte = 8'd0;
        endcase
        last_result = is_last;
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (cmd_push)
            mem[wr_reg] <= cmd_in;
    end

    // Queue pointers and slot sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            cnt_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd_push)
                wr_reg <= wr_reg + PW'(1);
            if (pop)
                rd_reg <= rd_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(cmd_push) - (PW+1)'(pop);
            if (pop)
                step_reg <= '0;
            else if (out_valid && out_ready)
                step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/rtp_h264_frame_depacketizer.sv
// Top level of the RTP H.264 depacketizer.
//
// Channel | Handshake           | Carries
// in      | in_valid/in_ready   | one payload byte with header fields
// out     | out_valid/out_ready | one Annex B byte or one frame verdict
// cfg     | cfg_valid/cfg_ready | register index and write data
//
// An accepted input item updates the front's frame state at once.
// Each item that causes results becomes one queue entry of up to seven results,
// which the back sends at one result per cycle while out_ready is high.
// Input is held only while the four-entry queue is full, until its head drains.
// Reset clears all state and the registers to their defaults.
`default_nettype none
module rtp_h264_frame_depacketizer #(
    parameter int LENGTH_BITS = rtpd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    input  wire logic        marker,
    input  wire logic [6:0]  rtp_pt,
    input  wire logic [15:0] seq_num,
    input  wire logic [31:0] rtp_timestamp,
    input  wire logic [31:0] ssrc,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             is_data,
    output logic             frame_end,
    output logic             frame_good,
    output logic [23:0]      frame_length,
    output logic [31:0]      frame_timestamp,
    output logic             last_result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);
    import rtpd_pkg::*;

    logic       pt_en_reg;
    logic [6:0] pt_val_reg;
    cmd_t       cmd;
    logic       cmd_any, room, in_fire;

    assign in_ready  = room;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_en_reg  <= 1'b0;
            pt_val_reg <= 7'd96;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PT_ENABLE: pt_en_reg  <= cfg_data[0];
                REG_PT_VALUE:  pt_val_reg <= cfg_data;
                default:       pt_en_reg  <= pt_en_reg;
            endcase
        end
    end

    rtpd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .clk, .rst_n, .in_fire, .payload_byte, .first_byte, .last_byte, .marker,
        .rtp_pt, .seq_num, .rtp_timestamp, .ssrc,
        .pt_filter_enable(pt_en_reg), .pt_value(pt_val_reg),
        .cmd, .cmd_any
    );

    rtpd_back u_back (
        .clk, .rst_n, .cmd_push(in_fire && cmd_any), .cmd_in(cmd), .cmd_room(room),
        .out_valid, .out_ready, .out_byte, .is_data, .frame_end, .frame_good,
        .frame_length, .frame_timestamp, .last_result
    );

endmodule
`default_nettype wire

FILE: src/rtpd_checker.sv
// Port-level checker for the depacketizer, bound to the top level.
`default_nettype none
module rtpd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        is_data,
    input wire logic        frame_end,
    input wire logic        frame_good,
    input wire logic [23:0] frame_length,
    input wire logic [7:0]  out_byte
);
    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("stalled result changed");

    // Data and verdict are exclusive.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_data != frame_end)
        else $error("result kind inconsistent");

    // A good frame has bytes.
    a_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_good |-> frame_length != 24'd0)
        else $error("good frame with no bytes");

    // Verdicts carry no byte.
    a_vbyte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> out_byte == 8'd0)
        else $error("verdict with byte");
endmodule

bind rtp_h264_frame_depacketizer rtpd_checker u_chk (
    .clk, .rst_n, .out_valid, .out_ready, .is_data, .frame_end, .frame_good,
    .frame_length, .out_byte
);
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the RTP H.264 depacketizer top level.
`timescale 1ns / 100ps

module testbench;
    import rtpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [23:0] LEN_SAT = 24'hFFFFFF;

    // One expected output result.
    typedef struct packed {
        logic [7:0]  byte_val;
        logic        data_flag;
        logic        end_flag;
        logic        good_flag;
        logic [23:0] len;
        logic [31:0] ts;
        logic        last_flag;
    } annexb_result_t;

    // One input item.
    typedef struct packed {
        logic [7:0]  pbyte;
        logic        first;
        logic        last;
        logic        mk;
        logic [6:0]  pt;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [31:0] src;
    } rtp_byte_t;

    // One row of the directed table.
    typedef struct {
        rtp_byte_t item;
        int        typed_count;
        logic      typed_is_verdict;
        logic      typed_good;
        logic [23:0] typed_len;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] payload_byte = '0;
    logic first_byte = 1'b0;
    logic last_byte = 1'b0;
    logic marker = 1'b0;
    logic [6:0] rtp_pt = '0;
    logic [15:0] seq_num = '0;
    logic [31:0] rtp_timestamp = '0;
    logic [31:0] ssrc = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_byte;
    logic is_data;
    logic frame_end;
    logic frame_good;
    logic [23:0] frame_length;
    logic [31:0] frame_timestamp;
    logic last_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [6:0] cfg_data = '0;

    rtp_h264_frame_depacketizer i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .payload_byte(payload_byte), .first_byte(first_byte), .last_byte(last_byte),
        .marker(marker), .rtp_pt(rtp_pt), .seq_num(seq_num),
        .rtp_timestamp(rtp_timestamp), .ssrc(ssrc),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(out_byte), .is_data(is_data), .frame_end(frame_end),
        .frame_good(frame_good), .frame_length(frame_length),
        .frame_timestamp(frame_timestamp), .last_result(last_result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Shadow copy of the block's state.
    logic        filt_en;
    logic [6:0]  filt_pt;
    logic        fr_active;
    logic [31:0] fr_ts;
    logic [31:0] fr_ssrc;
    logic [15:0] next_seq;
    logic        fr_damaged;
    logic        frag_open;
    pkt_class_t  cur_class;
    logic [1:0]  byte_pos;
    logic [2:0]  nri_bits;
    logic [23:0] fr_len;
    logic [7:0]  fu_hdr;
    logic        cur_marker;

    annexb_result_t pending_results[$];
    int error_count = 0;
    int idle_send_pct = 0;
    int stall_recv_pct = 0;
    int quiet_cycles = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic annexb_result_t data_result(input logic [7:0] b);
        annexb_result_t r;
        r = '0;
        r.byte_val = b;
        r.data_flag = 1'b1;
        return r;
    endfunction

    // Appends one data byte and advances the saturating frame length.
    task automatic push_data(inout annexb_result_t batch[$], input logic [7:0] b);
        batch.insert(batch.size(), data_result(b));
        if (fr_len != LEN_SAT)
            fr_len++;
    endtask

    task automatic push_start_code(inout annexb_result_t batch[$]);
        push_data(batch, 8'h00);
        push_data(batch, 8'h00);
        push_data(batch, 8'h00);
        push_data(batch, START_BYTE);
    endtask

    task automatic push_verdict(inout annexb_result_t batch[$], input logic good);
        annexb_result_t r;
        r = '0;
        r.end_flag = 1'b1;
        r.good_flag = good;
        r.len = fr_len;
        r.ts = fr_ts;
        batch.insert(batch.size(), r);
    endtask

    task automatic clear_frame_state();
        fr_active = 1'b0;
        fr_ts = '0;
        fr_ssrc = '0;
        next_seq = '0;
        fr_damaged = 1'b0;
        frag_open = 1'b0;
        fr_len = '0;
    endtask

    task automatic reset_shadow();
        filt_en = 1'b0;
        filt_pt = 7'd96;
        clear_frame_state();
        cur_class = CLS_IGNORE;
        byte_pos = '0;
        nri_bits = '0;
        fu_hdr = '0;
        cur_marker = 1'b0;
    endtask

    // Computes the Annex B results caused by one payload byte.
    task automatic depacketize_byte(input rtp_byte_t it, output annexb_result_t batch[$]);
        logic [1:0] pos;
        logic [4:0] nal_kind;
        logic good;
        batch = {};
        if (it.first) begin
            pos = 2'd0;
            cur_class = CLS_IGNORE;
            if (!(filt_en && it.pt != filt_pt)) begin
                nal_kind = it.pbyte[4:0] & NAL_TYPE_MASK;
                cur_marker = it.mk;
                if (!fr_active || it.ts != fr_ts || it.src != fr_ssrc) begin
                    if (fr_active)
                        push_verdict(batch, 1'b0);
                    clear_frame_state();
                    fr_active = 1'b1;
                    fr_ts = it.ts;
                    fr_ssrc = it.src;
                end else if (it.seq != next_seq) begin
                    fr_damaged = 1'b1;
                    frag_open = 1'b0;
                end
                next_seq = it.seq + 16'd1;
                if (nal_kind >= 5'd1 && nal_kind <= 5'd23) begin
                    cur_class = CLS_SINGLE;
                    frag_open = 1'b0;
                    push_start_code(batch);
                    push_data(batch, it.pbyte);
                end else if (nal_kind == NAL_FUA) begin
                    cur_class = CLS_FUA;
                    nri_bits = it.pbyte[7:5];
                end else begin
                    cur_class = CLS_SWALLOW;
                    fr_damaged = 1'b1;
                    frag_open = 1'b0;
                end
            end
        end else begin
            pos = byte_pos;
            if (cur_class == CLS_SINGLE) begin
                push_data(batch, it.pbyte);
            end else if (cur_class == CLS_FUA) begin
                if (pos == 2'd1) begin
                    fu_hdr = it.pbyte;
                    if (!it.pbyte[7] && !frag_open) begin
                        fr_damaged = 1'b1;
                        cur_class = CLS_SWALLOW;
                    end
                end else if (pos >= 2'd2) begin
                    if (pos == 2'd2 && fu_hdr[7]) begin
                        push_start_code(batch);
                        push_data(batch, {nri_bits, fu_hdr[4:0]});
                    end
                    push_data(batch, it.pbyte);
                end
            end
        end
        // End-of-packet handling.
        if (it.last && cur_class != CLS_IGNORE) begin
            if (cur_class == CLS_FUA) begin
                if (pos < 2'd2) begin
                    fr_damaged = 1'b1;
                    frag_open = 1'b0;
                end else if (fu_hdr[7]) begin
                    frag_open = !fu_hdr[6];
                end else if (fu_hdr[6]) begin
                    frag_open = 1'b0;
                end
            end
            if (cur_marker) begin
                good = fr_active && fr_len != 0 && !fr_damaged && !frag_open;
                push_verdict(batch, good);
                clear_frame_state();
            end
        end
        if (it.last)
            cur_class = CLS_IGNORE;
        byte_pos = (pos < 2'd3) ? pos + 2'd1 : 2'd3;
        if (batch.size() > 0)
            batch[batch.size() - 1].last_flag = 1'b1;
    endtask

    // Sends one item and queues its expected results.
    task automatic send_item(input rtp_byte_t it, output int n_results);
        annexb_result_t batch[$];
        while ($urandom_range(99) < idle_send_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        depacketize_byte(it, batch);
        n_results = batch.size();
        foreach (batch[k])
            pending_results.insert(pending_results.size(), batch[k]);
        in_valid <= 1'b1;
        payload_byte <= it.pbyte;
        first_byte <= it.first;
        last_byte <= it.last;
        marker <= it.mk;
        rtp_pt <= it.pt;
        seq_num <= it.seq;
        rtp_timestamp <= it.ts;
        ssrc <= it.src;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Waits for the results to drain, then lets the back end settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PT_ENABLE)
            filt_en = val[0];
        else
            filt_pt = val;
    endtask

    // Receiver: random stall and comparison with the oldest expectation.
    always @(posedge clk) begin
        annexb_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (out_byte !== want.byte_val)
                        report_mismatch($sformatf("out_byte %h want %h", out_byte, want.byte_val));
                    if (is_data !== want.data_flag)
                        report_mismatch($sformatf("is_data %b want %b", is_data, want.data_flag));
                    if (frame_end !== want.end_flag)
                        report_mismatch($sformatf("frame_end %b want %b", frame_end, want.end_flag));
                    if (frame_good !== want.good_flag)
                        report_mismatch($sformatf("frame_good %b want %b", frame_good,
                                                  want.good_flag));
                    if (frame_length !== want.len)
                        report_mismatch($sformatf("frame_length %0d want %0d", frame_length,
                                                  want.len));
                    if (frame_timestamp !== want.ts)
                        report_mismatch($sformatf("frame_timestamp %h want %h", frame_timestamp,
                                                  want.ts));
                    if (last_result !== want.last_flag)
                        report_mismatch($sformatf("last_result %b want %b", last_result,
                                                  want.last_flag));
                end
            end
            out_ready <= ($urandom_range(99) >= stall_recv_pct);
        end
    end

    // Watchdog on cycles without any accepted transfer.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic rtp_byte_t mk_item(input logic [7:0] b, input logic f, input logic l,
                                          input logic m, input logic [6:0] pt,
                                          input logic [15:0] seq, input logic [31:0] ts,
                                          input logic [31:0] src);
        rtp_byte_t it;
        it = {b, f, l, m, pt, seq, ts, src};
        return it;
    endfunction

    // Random well-formed packet state for the generator.
    logic [15:0] gen_seq;
    logic [31:0] gen_ts;
    logic [31:0] gen_src;

    // Builds one packet of random content, mostly well formed.
    task automatic random_packet(output rtp_byte_t pkt[$]);
        int len;
        int kind;
        logic [7:0] b0;
        logic [7:0] fu;
        logic [6:0] pt;
        pkt = {};
        kind = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 8);
        if ($urandom_range(5) == 0)
            gen_ts = $urandom();
        if ($urandom_range(30) == 0)
            gen_src = $urandom();
        gen_seq = ($urandom_range(12) == 0) ? 16'($urandom()) : gen_seq + 16'd1;
        pt = ($urandom_range(3) == 0) ? 7'($urandom()) : filt_pt;
        if (kind < 40)
            b0 = {3'($urandom()), 5'($urandom_range(1, 23))};
        else if (kind < 88)
            b0 = {3'($urandom()), NAL_FUA};
        else
            b0 = 8'($urandom());
        fu = 8'($urandom());
        if (kind >= 40 && kind < 88 && $urandom_range(1) == 1)
            fu[7] = 1'b1;
        for (int k = 0; k < len; k++)
            pkt.insert(pkt.size(), mk_item((k == 0) ? b0 : (k == 1) ? fu : 8'($urandom()),
                                           k == 0, k == len - 1, $urandom_range(2) == 0, pt,
                                           gen_seq, gen_ts, gen_src));
        // Occasional noise: stray byte or packet cut off early.
        if ($urandom_range(15) == 0)
            pkt.push_front(mk_item(8'($urandom()), 1'b0, 1'($urandom_range(1)), 1'b1,
                                   7'($urandom()), 16'($urandom()), $urandom(), $urandom()));
        if ($urandom_range(15) == 0 && pkt.size() > 1)
            pkt[pkt.size() - 1].last = 1'b0;
    endtask

    initial begin
        directed_row_t table_rows[$];
        rtp_byte_t pkt[$];
        int n;
        int sent;
        int phase_idle[4] = '{0, 82, 0, 9};
        int phase_stall[4] = '{0, 0, 82, 9};

        reset_shadow();
        gen_seq = 16'd100;
        gen_ts = 32'h1000;
        gen_src = 32'hCAFE0001;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; counts of -1 defer to the predictor alone.
        table_rows = '{
            // Single NAL with marker: five data bytes then a good verdict of length 6.
            '{mk_item(8'h65, 1'b1, 1'b0, 1'b1, 7'd96, 16'd0, 32'h0, 32'h0),
              5, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'hFF, 1'b0, 1'b1, 1'b0, 7'd0, 16'd0, 32'h0, 32'h0),
              2, 1'b1, 1'b1, 24'd6},
            // FU-A start and end fragments with all-ones timestamp and SSRC.
            '{mk_item(8'h7C, 1'b1, 1'b0, 1'b0, 7'd127, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF),
              0, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h85, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 32'h0, 32'h0),
              0, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'hAA, 1'b0, 1'b1, 1'b0, 7'd0, 16'd0, 32'h0, 32'h0),
              6, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h7C, 1'b1, 1'b0, 1'b0, 7'd127, 16'h0000, 32'hFFFFFFFF, 32'hFFFFFFFF),
              0, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h45, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 32'h0, 32'h0),
              0, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h00, 1'b0, 1'b1, 1'b0, 7'd0, 16'd0, 32'h0, 32'h0),
              -1, 1'b0, 1'b0, 24'd0},
            // Timestamp change abandons the frame; unsupported type damages the new one.
            '{mk_item(8'h18, 1'b1, 1'b0, 1'b1, 7'd5, 16'd7, 32'h1, 32'hFFFFFFFF),
              1, 1'b1, 1'b0, 24'd7},
            '{mk_item(8'h11, 1'b0, 1'b1, 1'b0, 7'd0, 16'd0, 32'h0, 32'h0),
              1, 1'b1, 1'b0, 24'd0},
            // Continuation fragment without an open one, then a short FU-A packet.
            '{mk_item(8'h5C, 1'b1, 1'b0, 1'b0, 7'd9, 16'd3, 32'h2, 32'h5),
              0, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h05, 1'b0, 1'b0, 1'b0, 7'd0, 16'd0, 32'h0, 32'h0),
              0, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h33, 1'b0, 1'b1, 1'b0, 7'd0, 16'd0, 32'h0, 32'h0),
              0, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h1C, 1'b1, 1'b1, 1'b1, 7'd9, 16'd4, 32'h2, 32'h5),
              1, 1'b1, 1'b0, 24'd0},
            // Sequence gap inside a frame, stray byte, type zero.
            '{mk_item(8'h01, 1'b1, 1'b1, 1'b0, 7'd9, 16'd10, 32'h3, 32'h5),
              5, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h01, 1'b1, 1'b1, 1'b1, 7'd9, 16'd12, 32'h3, 32'h5),
              -1, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h42, 1'b0, 1'b1, 1'b1, 7'd9, 16'd0, 32'h0, 32'h0),
              0, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h00, 1'b1, 1'b0, 1'b1, 7'd0, 16'd1, 32'h4, 32'h0),
              0, 1'b0, 1'b0, 24'd0},
            // New packet cuts the old one off mid-way.
            '{mk_item(8'h17, 1'b1, 1'b0, 1'b1, 7'd0, 16'd2, 32'h4, 32'h0),
              -1, 1'b0, 1'b0, 24'd0},
            '{mk_item(8'h99, 1'b0, 1'b1, 1'b0, 7'd0, 16'd0, 32'h0, 32'h0),
              -1, 1'b0, 1'b0, 24'd0}
        };

        foreach (table_rows[r]) begin
            annexb_result_t want;
            send_item(table_rows[r].item, n);
            if (table_rows[r].typed_count >= 0 && n != table_rows[r].typed_count)
                report_mismatch($sformatf("row %0d: %0d results, table says %0d", r, n,
                                          table_rows[r].typed_count));
            if (table_rows[r].typed_is_verdict && n > 0) begin
                want = pending_results[pending_results.size() - 1];
                if (!want.end_flag || want.good_flag !== table_rows[r].typed_good
                    || want.len !== table_rows[r].typed_len)
                    report_mismatch($sformatf("row %0d: verdict differs from table", r));
            end
        end

        // Random phases, each under its own register settings and idling mix.
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            idle_send_pct = phase_idle[ph];
            stall_recv_pct = phase_stall[ph];
            case (ph)
                0: write_reg(REG_PT_VALUE, 7'd0);
                1: begin
                    write_reg(REG_PT_ENABLE, 7'd1);
                    write_reg(REG_PT_VALUE, 7'd127);
                end
                2: write_reg(REG_PT_VALUE, 7'd96);
                default: write_reg(REG_PT_ENABLE, 7'd0);
            endcase
            while (sent < (ph + 1) * 90) begin
                random_packet(pkt);
                foreach (pkt[k]) begin
                    send_item(pkt[k], n);
                    sent++;
                end
            end
        end

        drain();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
